// ----- rtl/blur3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur3_pkg
// Shared types and constants for the 3x3 streaming blur.
// ----------------------------------------------------------------------------
package blur3_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int COLSUM_W   = 10;
    localparam int SUM_W      = 12;
    localparam int PROD_W     = 25;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

    localparam logic MODE_BOX   = 1'b0;
    localparam logic MODE_GAUSS = 1'b1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int SIZE_MIN     = 3;

    // floor(x / 9) == (x * RECIP_9) >> RECIP_SHIFT for x below 4096
    localparam logic [12:0] RECIP_9     = 13'd7282;
    localparam int          RECIP_SHIFT = 16;
    localparam int          GAUSS_SHIFT = 4;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } pix_col_t;

    typedef struct packed {
        logic [COLSUM_W-1:0] box;
        logic [COLSUM_W-1:0] gauss;
    } col_sum_t;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] lower;
    } line_pair_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             fe;
    } out_item_t;

endpackage

// ----- rtl/blur3_linebuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur3_linebuf
// Two line stores packed into one memory; registered read, one write port.
// ----------------------------------------------------------------------------
module blur3_linebuf
    import blur3_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output line_pair_t       rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  line_pair_t       wr_data
);

    line_pair_t mem [DEPTH];
    line_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/blur3_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur3_cell
// One window column: holds three pixels, passes them on when the window
// shifts, and forms the box and 1-2-1 weighted column sums.
// ----------------------------------------------------------------------------
module blur3_cell
    import blur3_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     shift_en,
    input  pix_col_t col_in,
    output pix_col_t col_out,
    output col_sum_t sums
);

    pix_col_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift_en)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out   = col_reg;
    assign sums.box  = COLSUM_W'(col_reg.top) + COLSUM_W'(col_reg.mid)
                     + COLSUM_W'(col_reg.bot);
    assign sums.gauss = COLSUM_W'(col_reg.top) + COLSUM_W'({col_reg.mid, 1'b0})
                      + COLSUM_W'(col_reg.bot);

endmodule

// ----- rtl/blur_3x3_stream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur_3x3_stream
// Streaming 3x3 box / Gaussian blur of an 8-bit raster frame.
// ----------------------------------------------------------------------------
// channel  | signals                                 | transfer
// ---------+-----------------------------------------+-------------------------
// input    | in_valid, in_stall, pixel_in            | in_valid & !in_stall
// output   | out_valid, out_stall, pixel_out,        | out_valid & !out_stall
//          | out_row, out_col, frame_end             |
// config   | cfg_we, cfg_index, cfg_wdata            | cfg_we
//
// One pixel per clock sustained while the output queue is not full; the line
// buffer memory is read and written once per transaction. A taken pixel is
// registered, then window shift, sum and divide lead into the output queue.
// Reset needs no clearing pass. A two-entry output queue absorbs output
// stalls; in_stall rises only when that queue is full.
// ----------------------------------------------------------------------------
module blur_3x3_stream
    import blur3_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      pixel_out,
    output logic [ROW_W-1:0]      out_row,
    output logic [COL_W-1:0]      out_col,
    output logic                  frame_end
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RST_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    // configuration
    logic [CW-1:0]    last_col_reg, width_last;
    logic [ROW_W-1:0] last_row_reg, height_last;
    logic             mode_reg;
    logic             geom_wr;

    always_comb
    begin
        if (cfg_wdata[WIDTH_W-1:0] < WIDTH_W'(SIZE_MIN))
        begin
            width_last = CW'(SIZE_MIN - 1);
        end
        else if (32'(cfg_wdata[WIDTH_W-1:0]) > 32'(MAX_WIDTH))
        begin
            width_last = CW'(MAX_WIDTH - 1);
        end
        else
        begin
            width_last = CW'(cfg_wdata[WIDTH_W-1:0] - WIDTH_W'(1));
        end

        if (cfg_wdata[HEIGHT_W-1:0] < HEIGHT_W'(SIZE_MIN))
        begin
            height_last = ROW_W'(SIZE_MIN - 1);
        end
        else if (cfg_wdata[HEIGHT_W-1:0] > HEIGHT_W'(HEIGHT_LIMIT))
        begin
            height_last = ROW_W'(HEIGHT_LIMIT - 1);
        end
        else
        begin
            height_last = ROW_W'(cfg_wdata[HEIGHT_W-1:0] - HEIGHT_W'(1));
        end
    end

    assign geom_wr = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= CW'(RST_W - 1);
            last_row_reg <= ROW_W'(HEIGHT_RESET - 1);
            mode_reg     <= MODE_GAUSS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  last_col_reg <= width_last;
                REG_HEIGHT: last_row_reg <= height_last;
                REG_MODE:   mode_reg     <= cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    // handshake
    logic [1:0] cnt_reg, cnt_next;
    logic       en, accept, push, pop;

    assign en       = (cnt_reg != 2'd2);
    assign in_stall = !en;
    assign accept   = in_valid && en;

    // raster position
    logic [CW-1:0]    col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (geom_wr)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (accept)
        begin
            if (col_cnt_reg == last_col_reg)
            begin
                col_cnt_next = '0;
                row_cnt_next = (row_cnt_reg == last_row_reg) ? '0
                             : row_cnt_reg + ROW_W'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // stage 1: line buffer read
    logic             s1_valid_reg, s1_emit_reg, s1_fe_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [ROW_W-1:0] s1_row_out_reg;
    logic [COL_W-1:0] s1_col_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg     <= pixel_in;
            s1_col_reg     <= col_cnt_reg;
            s1_emit_reg    <= (row_cnt_reg >= ROW_W'(2)) && (col_cnt_reg >= CW'(2));
            s1_fe_reg      <= (row_cnt_reg == last_row_reg) && (col_cnt_reg == last_col_reg);
            s1_row_out_reg <= row_cnt_reg - ROW_W'(1);
            s1_col_out_reg <= COL_W'(col_cnt_reg - CW'(1));
        end
    end

    line_pair_t lb_rdata, lb_wdata;

    assign lb_wdata.upper = lb_rdata.lower;
    assign lb_wdata.lower = s1_pix_reg;

    blur3_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_linebuf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_cnt_reg),
        .rd_data (lb_rdata),
        .wr_en   (en && s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wdata)
    );

    // window: three column cells, oldest at index 0
    pix_col_t chain [4];
    col_sum_t sums  [3];

    assign chain[3].top = lb_rdata.upper;
    assign chain[3].mid = lb_rdata.lower;
    assign chain[3].bot = s1_pix_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_cell
        blur3_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (en && s1_valid_reg),
            .col_in   (chain[i+1]),
            .col_out  (chain[i]),
            .sums     (sums[i])
        );
    end

    // stage 2: window sum
    logic             s2_valid_reg, s2_fe_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [SUM_W-1:0] box_total, gauss_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_row_reg <= s1_row_out_reg;
            s2_col_reg <= s1_col_out_reg;
            s2_fe_reg  <= s1_fe_reg;
        end
    end

    assign box_total   = SUM_W'(sums[0].box) + SUM_W'(sums[1].box) + SUM_W'(sums[2].box);
    assign gauss_total = SUM_W'(sums[0].gauss) + SUM_W'({sums[1].gauss, 1'b0})
                       + SUM_W'(sums[2].gauss);

    // stage 3: divide
    logic              s3_valid_reg, s3_mode_reg, s3_fe_reg;
    logic [SUM_W-1:0]  s3_sum_reg;
    logic [ROW_W-1:0]  s3_row_reg;
    logic [COL_W-1:0]  s3_col_reg;
    logic [PROD_W-1:0] prod;
    out_item_t         s3_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_sum_reg  <= (mode_reg == MODE_BOX) ? box_total : gauss_total;
            s3_mode_reg <= mode_reg;
            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
            s3_fe_reg   <= s2_fe_reg;
        end
    end

    assign prod        = PROD_W'(s3_sum_reg) * PROD_W'(RECIP_9);
    assign s3_item.pix = (s3_mode_reg == MODE_BOX) ? prod[RECIP_SHIFT +: PIX_W]
                       : s3_sum_reg[GAUSS_SHIFT +: PIX_W];
    assign s3_item.row = s3_row_reg;
    assign s3_item.col = s3_col_reg;
    assign s3_item.fe  = s3_fe_reg;

    // output queue
    out_item_t q_reg [2];
    logic      wr_ptr_reg, rd_ptr_reg;

    assign push = en && s3_valid_reg;
    assign pop  = (cnt_reg != 2'd0) && !out_stall;

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= s3_item;
        end
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign pixel_out = q_reg[rd_ptr_reg].pix;
    assign out_row   = q_reg[rd_ptr_reg].row;
    assign out_col   = q_reg[rd_ptr_reg].col;
    assign frame_end = q_reg[rd_ptr_reg].fe;

`ifndef SYNTHESIS
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_cnt_reg <= last_col_reg)
        else $error("column counter past last column");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_cnt_reg <= last_row_reg)
        else $error("row counter past last row");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !cfg_we && col_cnt_reg != last_col_reg
        |=> col_cnt_reg == $past(col_cnt_reg) + CW'(1))
        else $error("column counter did not advance on transaction");

    a_row_interior: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_row != '0)
        else $error("result on border row");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for blur_3x3_stream
// Streams raster pixels through the blur and predicts every blurred result
// (value, row, column, end-of-frame) with a local line store and window model.
// A short directed table covers constant frames, a lone bright center pixel,
// both kernels, size clamping, register masking, a write to the spare index
// and a frame restart. Then come the start of a frame at the largest width,
// a tall narrow frame where the receiver holds off for a long stretch, and
// random small frames with random register settings and random idling.
// ----------------------------------------------------------------------------
module tb;
    import blur3_pkg::*;

    localparam int MAX_W        = 2048;
    localparam int RAND_ITEMS   = 650;
    localparam int CALM_ITEMS   = 150;
    localparam int WIDE_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 200;
    localparam longint TIMEOUT_NS = 64'd16_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int unsigned GAUSS_WT [9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};

    typedef enum logic {OP_REG, OP_PIX} step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        logic [7:0]            count;
        logic                  typed;
        out_item_t             res;
    } plan_row_t;

    localparam int PLAN_LEN = 24;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{OP_REG, REG_WIDTH,  13'd0,      8'd0,  1'b0, '0},
        '{OP_REG, REG_HEIGHT, 13'd2,      8'd0,  1'b0, '0},
        '{OP_REG, REG_MODE,   13'h1ffe,   8'd0,  1'b0, '0},
        '{OP_PIX, REG_WIDTH,  13'd255,    8'd9,  1'b1, '{8'd255, 12'd1, 11'd1, 1'b1}},
        '{OP_REG, REG_MODE,   13'h0001,   8'd0,  1'b0, '0},
        '{OP_PIX, REG_WIDTH,  13'd255,    8'd9,  1'b1, '{8'd255, 12'd1, 11'd1, 1'b1}},
        '{OP_PIX, REG_WIDTH,  13'd0,      8'd9,  1'b1, '{8'd0, 12'd1, 11'd1, 1'b1}},
        '{OP_PIX, REG_WIDTH,  13'd0,      8'd4,  1'b0, '0},
        '{OP_PIX, REG_WIDTH,  13'd255,    8'd1,  1'b0, '0},
        '{OP_PIX, REG_WIDTH,  13'd0,      8'd4,  1'b1, '{8'd63, 12'd1, 11'd1, 1'b1}},
        '{OP_REG, REG_MODE,   13'h0000,   8'd0,  1'b0, '0},
        '{OP_PIX, REG_WIDTH,  13'd0,      8'd4,  1'b0, '0},
        '{OP_PIX, REG_WIDTH,  13'd255,    8'd1,  1'b0, '0},
        '{OP_PIX, REG_WIDTH,  13'd0,      8'd4,  1'b1, '{8'd28, 12'd1, 11'd1, 1'b1}},
        '{OP_PIX, REG_WIDTH,  13'd255,    8'd5,  1'b0, '0},
        '{OP_REG, REG_SPARE,  13'h1fff,   8'd0,  1'b0, '0},
        '{OP_PIX, REG_WIDTH,  13'd255,    8'd4,  1'b1, '{8'd255, 12'd1, 11'd1, 1'b1}},
        '{OP_REG, REG_WIDTH,  13'h1005,   8'd0,  1'b0, '0},
        '{OP_REG, REG_HEIGHT, 13'd4,      8'd0,  1'b0, '0},
        '{OP_PIX, REG_WIDTH,  13'h00a5,   8'd7,  1'b0, '0},
        '{OP_REG, REG_HEIGHT, 13'd4,      8'd0,  1'b0, '0},
        '{OP_PIX, REG_WIDTH,  13'h005a,   8'd20, 1'b1, '{8'd90, 12'd2, 11'd3, 1'b1}},
        '{OP_REG, REG_MODE,   13'h0001,   8'd0,  1'b0, '0},
        '{OP_PIX, REG_WIDTH,  13'h0081,   8'd20, 1'b1, '{8'd129, 12'd2, 11'd3, 1'b1}}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel_in;
    logic                  out_valid;
    logic                  out_stall;
    logic [PIX_W-1:0]      pixel_out;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  frame_end;

    // blur model state
    bit [PIX_W-1:0]    ln_upper [MAX_W];
    bit [PIX_W-1:0]    ln_lower [MAX_W];
    bit [PIX_W-1:0]    win [9];
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;
    logic                kmode;

    out_item_t blur_q [$];

    int  err_cnt;
    int  pix_accepted;
    int  results_seen;
    int  frames_done;
    int  reg_writes;
    int  in_hold_cycles;
    int  gap_pct;
    int  stall_pct;
    bit  calm;

    blur_3x3_stream #(.MAX_WIDTH(MAX_W)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .out_row   (out_row),
        .out_col   (out_col),
        .frame_end (frame_end)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic void flag_error(input string what);
        err_cnt++;
        if (err_cnt <= 10)
            $display("[%0t] %s", $time, what);
    endfunction

    function automatic int unsigned eff_w();
        if (cfg_width < SIZE_MIN)
            return SIZE_MIN;
        if (cfg_width > MAX_W)
            return MAX_W;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_h();
        if (cfg_height < SIZE_MIN)
            return SIZE_MIN;
        if (cfg_height > HEIGHT_LIMIT)
            return HEIGHT_LIMIT;
        return cfg_height;
    endfunction

    function automatic bit blur_predict(input logic [PIX_W-1:0] px, output out_item_t res);
        int unsigned w;
        int unsigned h;
        int unsigned acc;
        int k;
        bit [PIX_W-1:0] top;
        bit [PIX_W-1:0] mid;
        bit hit;
        w = eff_w();
        h = eff_h();
        top = ln_upper[col_pos];
        mid = ln_lower[col_pos];
        ln_upper[col_pos] = mid;
        ln_lower[col_pos] = px;
        for (k = 0; k < 3; k++)
        begin
            win[3*k]   = win[3*k+1];
            win[3*k+1] = win[3*k+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        hit = (row_pos >= 2) && (col_pos >= 2);
        res = '0;
        if (hit)
        begin
            acc = 0;
            for (k = 0; k < 9; k++)
                acc += (kmode == MODE_BOX) ? win[k] : win[k] * GAUSS_WT[k];
            res.pix = (kmode == MODE_BOX) ? PIX_W'(acc / 9) : PIX_W'(acc / 16);
            res.row = ROW_W'(row_pos - 1);
            res.col = COL_W'(col_pos - 1);
            res.fe  = (row_pos + 1 >= h) && (col_pos + 1 >= w);
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos++;
        return hit;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] px);
        out_item_t res;
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (blur_predict(px, res))
            blur_q.push_back(res);
        pix_accepted++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (blur_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_index <= idx;
        cfg_wdata <= data;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:
            begin
                cfg_width = data[WIDTH_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            REG_HEIGHT:
            begin
                cfg_height = data[HEIGHT_W-1:0];
                col_pos = 0;
                row_pos = 0;
            end
            REG_MODE:
                kmode = data[0];
            default:
                ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && in_valid && in_stall)
            in_hold_cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (frame_end)
                frames_done++;
            if (blur_q.size() == 0)
                flag_error($sformatf("unexpected transaction pix=%0d row=%0d col=%0d fe=%0b",
                                     pixel_out, out_row, out_col, frame_end));
            else
            begin
                want = blur_q.pop_front();
                if (pixel_out !== want.pix || out_row !== want.row
                    || out_col !== want.col || frame_end !== want.fe)
                    flag_error($sformatf({"mismatch exp pix=%0d row=%0d col=%0d fe=%0b",
                                          " got pix=%0d row=%0d col=%0d fe=%0b"},
                                         want.pix, want.row, want.col, want.fe,
                                         pixel_out, out_row, out_col, frame_end));
            end
        end
    end

    // receiver stalls: random bursts plus one long hold-off
    initial
    begin : rx_side
        int burst;
        int hold;
        bit pressed;
        burst = 0;
        pressed = 1'b0;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!pressed && pix_accepted >= HOLD_AFTER)
            begin
                pressed = 1'b1;
                out_stall <= 1'b1;
                for (hold = 0; hold < HOLD_CYCLES; hold++)
                    @(posedge clk);
            end
            else if (burst > 0)
                burst--;
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                burst = $urandom_range(0, 12);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int k;
        int rand_done;
        int n;
        int unsigned w;
        int unsigned h;
        bit tall;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        pixel_in  = '0;
        cfg_width  = WIDTH_W'(WIDTH_RESET);
        cfg_height = HEIGHT_W'(HEIGHT_RESET);
        kmode      = MODE_GAUSS;
        col_pos    = 0;
        row_pos    = 0;
        err_cnt = 0;
        pix_accepted = 0;
        results_seen = 0;
        frames_done = 0;
        reg_writes = 0;
        in_hold_cycles = 0;
        gap_pct = 15;
        stall_pct = 15;
        calm = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (PLAN[i].kind == OP_REG)
                write_reg(PLAN[i].idx, PLAN[i].value);
            else
            begin
                for (k = 0; k < PLAN[i].count; k++)
                    send_pixel(PLAN[i].value[PIX_W-1:0]);
                if (PLAN[i].typed)
                begin
                    if (blur_q.size() == 0)
                        blur_q.push_back(PLAN[i].res);
                    else
                        blur_q[blur_q.size()-1] = PLAN[i].res;
                end
            end
        end

        // start of the widest frame; too short for any result
        write_reg(REG_WIDTH, 13'h1fff);
        write_reg(REG_HEIGHT, 13'd0);
        write_reg(REG_MODE, CFG_DATA_W'($urandom));
        repeat (WIDE_ITEMS) send_pixel(rand_pixel());

        // tallest height, narrowest width, partial frame; long hold-off lands here
        write_reg(REG_WIDTH, 13'd3);
        write_reg(REG_HEIGHT, 13'h1fff);
        repeat (3 * 40) send_pixel(rand_pixel());

        rand_done = 0;
        while (rand_done < RAND_ITEMS)
        begin
            calm = (rand_done >= RAND_ITEMS - CALM_ITEMS);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 30;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 10;
                default: stall_pct = 30;
            endcase
            if ($urandom_range(0, 5) == 0)
                write_reg(REG_SPARE, CFG_DATA_W'($urandom));
            if ($urandom_range(0, 2) != 0)
                write_reg(REG_WIDTH, {1'($urandom_range(0, 1)), 12'($urandom_range(0, 12))});
            if ($urandom_range(0, 2) != 0)
            begin
                tall = ($urandom_range(0, 9) == 0);
                write_reg(REG_HEIGHT, tall ? 13'($urandom_range(4097, 8191))
                                           : 13'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 1) != 0)
                write_reg(REG_MODE, CFG_DATA_W'($urandom));
            w = eff_w();
            h = eff_h();
            if (h > 16)
                n = w * $urandom_range(3, 10);
            else
            begin
                n = w * h * $urandom_range(1, 2);
                if ($urandom_range(0, 3) == 0)
                    n += $urandom_range(1, w * h - 1);
            end
            repeat (n) send_pixel(rand_pixel());
            rand_done += n;
        end

        wait_idle();
        $display("%0d pixels sent, %0d results checked, %0d frame ends, %0d register writes",
                 pix_accepted, results_seen, frames_done, reg_writes);
        $display("input held off %0d cycles; small frames, clamped sizes, both kernels; %0d errors",
                 in_hold_cycles, err_cnt);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
